// ===== src/prr_pkg.sv =====
// Package for the polyphase rational resampler: field widths, register
// indexes, function codes and limits shared by the interfaces and the RTL.
// No dependencies.
`default_nettype none

package prr_pkg;

    // Payload widths of the item and result fields
    localparam int SAMPLE_W    = 16;
    localparam int COEF_ADDR_W = 13;

    // Configuration channel
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INT_STEP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_STEP   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT   = 2'd3;

    // Register widths and reset values
    localparam int PHASE_COUNT_W = 9;
    localparam int INT_STEP_W    = 7;
    localparam int FRAC_STEP_W   = 8;
    localparam int TAP_COUNT_W   = 6;

    localparam logic [PHASE_COUNT_W-1:0] PHASE_COUNT_RST = 9'd1;
    localparam logic [INT_STEP_W-1:0]    INT_STEP_RST    = 7'd1;
    localparam logic [FRAC_STEP_W-1:0]   FRAC_STEP_RST   = 8'd0;
    localparam logic [TAP_COUNT_W-1:0]   TAP_COUNT_RST   = 6'd32;

    // Input function codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_COEF = 1'b1;

    // Phase and skip state
    localparam int PHASE_W  = 8;
    localparam int SKIP_W   = 7;
    localparam int SKIP_MAX = 127;

    // Outputs emitted per pushed sample at most
    localparam int MAX_OUT = 64;
    localparam int COUNT_W = 7;

    // Coefficients are Q1.15; the address field spans 8192 entries
    localparam int COEF_FRAC_BITS = 15;
    localparam int ROUND_HALF     = 1 << (COEF_FRAC_BITS - 1);
    localparam int COEF_ADDR_SPAN = 1 << COEF_ADDR_W;

endpackage

`default_nettype wire

// ===== src/prr_if.sv =====
// Valid/ready channel interfaces of the polyphase rational resampler:
// input items, result items and configuration writes.
// Depends on prr_pkg.
`default_nettype none

interface prr_in_if import prr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [COEF_ADDR_W-1:0] coef_addr;
    logic signed [SAMPLE_W-1:0] coef_value;

    modport source (output valid, func, sample_in, coef_addr, coef_value, input ready);
    modport sink   (input valid, func, sample_in, coef_addr, coef_value, output ready);
endinterface

interface prr_out_if import prr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_run;

    modport source (output valid, sample_out, last_of_run, input ready);
    modport sink   (input valid, sample_out, last_of_run, output ready);
endinterface

interface prr_cfg_if import prr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/polyphase_rational_resampler.sv =====
// Polyphase rational resampler with one shared multiply-accumulate.
// Coefficient store and tap window live in synchronous memories.
// Depends on prr_pkg and the channel interfaces in prr_if.sv.
//
// Usage:
//   i_in carries one transaction per item: func FUNC_COEF writes coef_value
//   into the coefficient store at coef_addr, func FUNC_PUSH pushes sample_in.
//   Before a pushed sample enters the tap window, up to MAX_OUT outputs that
//   are due are sent on o_out; last_of_run marks the final output of that push.
//   i_cfg writes phase_count, int_step, frac_step and tap_count by index and is
//   always ready. Write it only while the block is idle; nothing enforces it.
// Sequence:
//   A coefficient write is taken in the idle state. A push runs, for each
//   output it produces, address setup, one memory read per tap through the
//   single multiplier, a pipeline drain and a step that rounds, saturates and
//   loads the output register; then the sample is shifted into the window.
//   One item is worked on at a time.
// Reset and stall:
//   Reset restores the registers, zeroes phase and skip and marks the whole
//   tap window as zero. The coefficient store is not cleared and must be
//   written before use. A finished output waits in the output register;
//   a new item is still taken, and its first output holds until o_out frees.
`default_nettype none

module polyphase_rational_resampler import prr_pkg::*; #(
    parameter int TAPS        = 32,
    parameter int PHASES      = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prr_in_if.sink    i_in,
    prr_out_if.source o_out,
    prr_cfg_if.sink   i_cfg
);

    // Store and datapath sizing
    localparam int COEF_DEPTH  = PHASES * TAPS;
    localparam int STORE_DEPTH = (COEF_DEPTH < COEF_ADDR_SPAN) ? COEF_DEPTH : COEF_ADDR_SPAN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int TAPS_AW     = $clog2(TAPS);
    localparam int WIN_AW      = TAPS_AW;
    localparam int CA_W        = (PHASE_W + TAPS_AW > STORE_AW) ? PHASE_W + TAPS_AW : STORE_AW;
    localparam int NT_W        = $clog2(TAPS + 1);
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = PROD_W + TAPS_AW;
    localparam int RW          = ACC_W + 1;
    localparam int QW          = RW - COEF_FRAC_BITS;
    localparam int CW0         = (QW > SAMPLE_BITS + 1) ? QW : SAMPLE_BITS + 1;
    localparam int CW          = (CW0 > SAMPLE_W + 1) ? CW0 : SAMPLE_W + 1;

    localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH,
        ST_SHIFT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [PHASE_COUNT_W-1:0] r_phase_count;
    logic [INT_STEP_W-1:0]    r_int_step;
    logic [FRAC_STEP_W-1:0]   r_frac_step;
    logic [TAP_COUNT_W-1:0]   r_tap_count;

    // Sequencer state
    logic [PHASE_W-1:0]         r_phase;
    logic [SKIP_W-1:0]          r_skip;
    logic [COUNT_W-1:0]         r_count;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [NT_W-1:0]            r_j;
    logic [WIN_AW-1:0]          r_wrd;
    logic [WIN_AW-1:0]          r_wp;
    logic [CA_W-1:0]            r_caddr;
    logic [TAPS-1:0]            r_win_vld;

    // Output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;

    // Memories and read data
    logic signed [SAMPLE_W-1:0] r_coef_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_win_mem  [TAPS];
    logic signed [SAMPLE_W-1:0] r_coef_q;
    logic signed [SAMPLE_W-1:0] r_win_q;
    logic                       r_coef_ok;
    logic                       r_win_ok;

    // MAC pipeline
    logic                     r_p1;
    logic                     r_p2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // Combinational control
    logic                     in_acc;
    logic                     cfg_acc;
    logic                     out_free;
    logic                     load_out;
    logic                     issue;
    logic                     coef_we;
    logic                     win_we;
    logic [NT_W-1:0]          n_taps;
    logic [TAP_COUNT_W-1:0]   tc_lo;
    logic [WIN_AW:0]          w_sum;
    logic [WIN_AW-1:0]        win_start;
    logic [PHASE_COUNT_W-1:0] pc_eff;
    logic [PHASE_COUNT_W-1:0] p_sum;
    logic [PHASE_COUNT_W-1:0] p_adv;
    logic [SKIP_W:0]          s_adv;
    logic                     wrap;
    logic [PHASE_W-1:0]       n_phase;
    logic [SKIP_W-1:0]        n_skip;
    logic                     last;
    logic signed [RW-1:0]     rnd;
    logic signed [QW-1:0]     q;
    logic signed [CW-1:0]     q_ext;
    logic signed [CW-1:0]     sat;

    // Handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.last_of_run = r_out_last;

    assign out_free = !r_out_valid || o_out.ready;
    assign load_out = (r_state == ST_FINISH) && out_free;
    assign issue    = (r_state == ST_MAC);
    assign coef_we  = in_acc && (i_in.func == FUNC_COEF) && (32'(i_in.coef_addr) < STORE_DEPTH);
    assign win_we   = (r_state == ST_SHIFT);

    // Taps in use: round down to a multiple of four, hold within 4..TAPS
    always_comb begin
        tc_lo = {r_tap_count[TAP_COUNT_W-1:2], 2'b00};
        if (tc_lo < TAP_COUNT_W'(4)) begin
            tc_lo = TAP_COUNT_W'(4);
        end
        if (32'(tc_lo) > TAPS) begin
            n_taps = NT_W'(TAPS);
        end else begin
            n_taps = NT_W'(tc_lo);
        end
    end

    // Oldest tap in use sits TAPS - n slots after the write pointer
    always_comb begin
        w_sum = {1'b0, r_wp} + (WIN_AW + 1)'(TAPS - 32'(n_taps));
        if (32'(w_sum) >= TAPS) begin
            win_start = WIN_AW'(32'(w_sum) - TAPS);
        end else begin
            win_start = WIN_AW'(w_sum);
        end
    end

    // Phase and skip advance after one output
    always_comb begin
        pc_eff = (r_phase_count == '0) ? PHASE_COUNT_W'(1) : r_phase_count;
        p_sum  = PHASE_COUNT_W'(r_phase) + PHASE_COUNT_W'(r_frac_step);
        wrap   = (p_sum >= pc_eff);
        p_adv  = wrap ? p_sum - pc_eff : p_sum;
        s_adv  = (SKIP_W + 1)'(r_skip) + (SKIP_W + 1)'(r_int_step) + (SKIP_W + 1)'(wrap);
        n_phase = p_adv[PHASE_W-1:0];
        n_skip  = (32'(s_adv) > SKIP_MAX) ? SKIP_W'(SKIP_MAX) : s_adv[SKIP_W-1:0];
        last    = (n_skip != '0) || (r_count == COUNT_W'(MAX_OUT - 1));
    end

    // Round half up, then saturate to SAMPLE_BITS
    always_comb begin
        rnd   = RW'(r_acc) + RW'(ROUND_HALF);
        q     = QW'(rnd >>> COEF_FRAC_BITS);
        q_ext = CW'(q);
        if (q_ext > SAT_HI) begin
            sat = SAT_HI;
        end else if (q_ext < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = q_ext;
        end
    end

    // Coefficient store: write from input, read one tap a cycle
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[i_in.coef_addr[STORE_AW-1:0]] <= i_in.coef_value;
        end
        if (issue) begin
            r_coef_q <= r_coef_mem[r_caddr[STORE_AW-1:0]];
        end
    end

    // Tap window: circular buffer, write at the pointer on a push
    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win_mem[r_wp] <= r_sample;
        end
        if (issue) begin
            r_win_q <= r_win_mem[r_wrd];
        end
    end

    // Multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= issue;
            r_p2 <= r_p1;
            if (issue) begin
                r_win_ok  <= r_win_vld[r_wrd];
                r_coef_ok <= (32'(r_caddr) < STORE_DEPTH);
            end
            if (r_p1) begin
                r_prod <= (r_win_ok && r_coef_ok) ? r_win_q * r_coef_q : PROD_W'(0);
            end
            if (r_state == ST_SETUP) begin
                r_acc <= '0;
            end else if (r_p2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase_count <= PHASE_COUNT_RST;
            r_int_step    <= INT_STEP_RST;
            r_frac_step   <= FRAC_STEP_RST;
            r_tap_count   <= TAP_COUNT_RST;
            r_phase       <= '0;
            r_skip        <= '0;
            r_count       <= '0;
            r_wp          <= '0;
            r_win_vld     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // Configuration writes
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_PHASE_COUNT: r_phase_count <= i_cfg.data[PHASE_COUNT_W-1:0];
                    CFG_INT_STEP:    r_int_step    <= i_cfg.data[INT_STEP_W-1:0];
                    CFG_FRAC_STEP:   r_frac_step   <= i_cfg.data[FRAC_STEP_W-1:0];
                    CFG_TAP_COUNT:   r_tap_count   <= i_cfg.data[TAP_COUNT_W-1:0];
                    default: ;
                endcase
            end

            // Drop the output once the sink takes it, unless a new one loads
            if (o_out.valid && o_out.ready && !load_out) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.func == FUNC_PUSH)) begin
                        r_sample <= i_in.sample_in;
                        r_count  <= '0;
                        r_state  <= (r_skip == '0) ? ST_SETUP : ST_SHIFT;
                    end
                end
                ST_SETUP: begin
                    r_j     <= '0;
                    r_wrd   <= win_start;
                    r_caddr <= CA_W'(r_phase) * CA_W'(TAPS);
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    // Advance one tap a cycle
                    r_j     <= r_j + NT_W'(1);
                    r_caddr <= r_caddr + CA_W'(1);
                    r_wrd   <= (r_wrd == WIN_AW'(TAPS - 1)) ? '0 : r_wrd + WIN_AW'(1);
                    if (r_j == n_taps - NT_W'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_p1 && !r_p2) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // Load the output and advance phase and skip
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= sat[SAMPLE_W-1:0];
                        r_out_last   <= last;
                        r_phase      <= n_phase;
                        r_skip       <= n_skip;
                        r_count      <= r_count + COUNT_W'(1);
                        r_state      <= last ? ST_SHIFT : ST_SETUP;
                    end
                end
                ST_SHIFT: begin
                    // Shift the sample into the window and count a nonzero skip down
                    if (r_skip != '0) begin
                        r_skip <= r_skip - SKIP_W'(1);
                    end
                    r_win_vld[r_wp] <= 1'b1;
                    r_wp    <= (r_wp == WIN_AW'(TAPS - 1)) ? '0 : r_wp + WIN_AW'(1);
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Never more than the per-push output limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_OUT)
        else $error("output count exceeds per-push limit");

    // Rounding only sees a fully drained accumulator
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (!r_p1 && !r_p2))
        else $error("accumulator read before pipeline drained");

    // Tap index stays inside the taps in use
    a_tap_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_j < n_taps))
        else $error("tap index beyond taps in use");

    // A coefficient write leaves phase and skip untouched
    a_coef_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.func == FUNC_COEF)) |=> ($stable(r_phase) && $stable(r_skip)))
        else $error("coefficient write disturbed phase or skip");

    // The last output of a run is followed by the window shift
    a_last_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && last) |=> (r_state == ST_SHIFT))
        else $error("last output not followed by window shift");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_polyphase_rational_resampler.sv =====
// Testbench for polyphase_rational_resampler: fills the first coefficient phases, runs a
// directed table and then random traffic under several resampling ratios.
// Depends on prr_pkg, the channel interfaces in prr_if.sv and the block itself.
`timescale 1ns / 100ps

module tb_polyphase_rational_resampler;
    import prr_pkg::*;

    localparam int    TAPS          = 32;
    localparam int    PHASES        = 256;
    localparam int    COEF_DEPTH    = TAPS * PHASES;
    localparam int    FILL_PHASES   = 4;
    localparam int    CLK_PERIOD    = 12;
    localparam int    SETTLE_CYCLES = 12;
    localparam int    WATCHDOG_NS   = 60_000_000;
    localparam longint SAT_HI       = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO       = -SAT_HI - 1;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // One resampled output as it should appear on o_out
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
    } resampled_t;

    // Directed row: data is the sample for a push, the coefficient for a write
    typedef struct packed {
        logic                   func;
        logic [COEF_ADDR_W-1:0] addr;
        logic [SAMPLE_W-1:0]    data;
        logic                   typed;
        logic [SAMPLE_W-1:0]    typed_val;
    } dir_row_t;

    // Resampling ratio of one random phase and its length in items
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pc;
        logic [CFG_DATA_W-1:0] istep;
        logic [CFG_DATA_W-1:0] fstep;
        logic [CFG_DATA_W-1:0] taps;
        logic [15:0]           items;
    } ratio_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prr_in_if  in_ch ();
    prr_out_if out_ch ();
    prr_cfg_if cfg_ch ();

    polyphase_rational_resampler #(
        .TAPS        (TAPS),
        .PHASES      (PHASES),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Directed table, run with tap_count 4 so that taps 0..3 of phase 0 are used
    dir_row_t dir_rows [21] = '{
        '{FUNC_PUSH, 13'd0,    16'h7FFF, 1'b1, 16'h0000},  // window still zero
        '{FUNC_COEF, 13'd0,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_COEF, 13'd1,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_COEF, 13'd2,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_COEF, 13'd3,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h8000, 1'b1, 16'h7FFF},  // positive saturation
        '{FUNC_PUSH, 13'd0,    16'h8000, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h8000, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h8000, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h0001, 1'b1, 16'h8000},  // negative saturation
        '{FUNC_COEF, 13'd0,    16'h0000, 1'b0, 16'h0000},
        '{FUNC_COEF, 13'd1,    16'h0000, 1'b0, 16'h0000},
        '{FUNC_COEF, 13'd2,    16'h0000, 1'b0, 16'h0000},
        '{FUNC_COEF, 13'd3,    16'h4000, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'hFFFF, 1'b1, 16'h0001},  // +0.5 rounds up
        '{FUNC_PUSH, 13'd0,    16'h0000, 1'b1, 16'h0000},  // -0.5 rounds up to zero
        '{FUNC_COEF, 13'd8191, 16'h8000, 1'b0, 16'h0000},
        '{FUNC_PUSH, 13'd0,    16'h5555, 1'b0, 16'h0000}
    };

    // Ratios of the random phases. Each keeps the phase count at most FILL_PHASES
    // (or the frac step zero) and the frac step at most the phase count, so the
    // phase never leaves the filled coefficient phases.
    ratio_t ratios [9] = '{
        '{9'd3,   9'd0,   9'd2,   9'd8,   16'd20},
        '{9'd4,   9'd0,   9'd3,   9'd32,  16'd20},
        '{9'd0,   9'd0,   9'd0,   9'd4,   16'd10},  // more outputs due than one push sends
        '{9'd3,   9'd0,   9'd3,   9'd13,  16'd20},  // frac step equal to phase count
        '{9'd4,   9'd2,   9'd3,   9'd6,   16'd20},
        '{9'd2,   9'd1,   9'd1,   9'd0,   16'd15},  // tap count below range
        '{9'd3,   9'd0,   9'd1,   9'd20,  16'd20},
        '{9'd2,   9'd64,  9'd1,   9'd28,  16'd20},
        '{9'h1FF, 9'h1FF, 9'd0,   9'h1FF, 16'd15}   // skip count reaches SKIP_MAX
    };

    // Resampler state as the block should hold it
    logic [PHASE_COUNT_W-1:0]   pc_reg    = PHASE_COUNT_RST;
    logic [INT_STEP_W-1:0]      istep_reg = INT_STEP_RST;
    logic [FRAC_STEP_W-1:0]     fstep_reg = FRAC_STEP_RST;
    logic [TAP_COUNT_W-1:0]     taps_reg  = TAP_COUNT_RST;
    logic signed [SAMPLE_W-1:0] win [TAPS];
    logic signed [SAMPLE_W-1:0] coef_mem [COEF_DEPTH];
    logic [PHASE_W-1:0]         phase     = '0;
    logic [SKIP_W-1:0]          skip      = '0;

    resampled_t due_outputs [$];
    bit         mismatch_seen = 1'b0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    logic       row_typed;
    logic [SAMPLE_W-1:0] row_typed_val;

    initial begin
        for (int k = 0; k < TAPS; k++) win[k] = '0;
    end

    // Emit up to MAX_OUT due outputs before the sample enters the window, then shift it in
    task automatic resample_push(input logic signed [SAMPLE_W-1:0] smp, output int n_out,
                                 output logic signed [SAMPLE_W-1:0] vals [MAX_OUT]);
        int     n;
        int     pcw;
        int     p;
        int     s;
        longint acc;
        n_out = 0;
        n = int'(taps_reg) & ~3;
        if (n < 4) n = 4;
        if (n > TAPS) n = TAPS;
        while (skip == 0 && n_out < MAX_OUT) begin
            acc = 0;
            for (int j = 0; j < n; j++)
                acc += longint'(win[TAPS-n+j]) * longint'(coef_mem[int'(phase) * TAPS + j]);
            acc = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
            if (acc > SAT_HI) acc = SAT_HI;
            if (acc < SAT_LO) acc = SAT_LO;
            vals[n_out] = acc[SAMPLE_W-1:0];
            n_out++;
            // advance the phase; a wrap skips one more input sample
            pcw = (pc_reg == 0) ? 1 : int'(pc_reg);
            p = int'(phase) + int'(fstep_reg);
            s = int'(skip) + int'(istep_reg);
            if (p >= pcw) begin
                p -= pcw;
                s++;
            end
            phase = p[PHASE_W-1:0];
            skip = (s > SKIP_MAX) ? SKIP_W'(SKIP_MAX) : SKIP_W'(s);
        end
        if (skip != 0) skip--;
        for (int k = 0; k < TAPS - 1; k++) win[k] = win[k+1];
        win[TAPS-1] = smp;
    endtask

    // Track accepted transactions on all three channels
    always @(posedge i_clk) begin : output_check
        logic signed [SAMPLE_W-1:0] vals [MAX_OUT];
        int         n_out;
        resampled_t want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_outputs.size() == 0) begin
                    $display("%0t unexpected output: expected none, actual %0d last %0b",
                             $time, out_ch.sample_out, out_ch.last_of_run);
                    mismatch_seen = 1'b1;
                end else begin
                    want = due_outputs.pop_front();
                    if (out_ch.sample_out !== want.smp) begin
                        $display("%0t sample_out mismatch: expected %0d, actual %0d",
                                 $time, want.smp, out_ch.sample_out);
                        mismatch_seen = 1'b1;
                    end
                    if (out_ch.last_of_run !== want.last) begin
                        $display("%0t last_of_run mismatch: expected %0b, actual %0b",
                                 $time, want.last, out_ch.last_of_run);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.func == FUNC_COEF) begin
                    if (int'(in_ch.coef_addr) < COEF_DEPTH)
                        coef_mem[in_ch.coef_addr] = in_ch.coef_value;
                end else begin
                    resample_push(in_ch.sample_in, n_out, vals);
                    if (row_typed)
                        due_outputs.push_back('{row_typed_val, 1'b1});
                    else
                        for (int k = 0; k < n_out; k++)
                            due_outputs.push_back('{vals[k], k == n_out - 1});
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_PHASE_COUNT: pc_reg    = cfg_ch.data[PHASE_COUNT_W-1:0];
                    CFG_INT_STEP:    istep_reg = cfg_ch.data[INT_STEP_W-1:0];
                    CFG_FRAC_STEP:   fstep_reg = cfg_ch.data[FRAC_STEP_W-1:0];
                    CFG_TAP_COUNT:   taps_reg  = cfg_ch.data[TAP_COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Random backpressure on the result channel
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Send one input transaction after a random gap and hold it until taken
    task automatic send_txn(input logic func, input logic [SAMPLE_W-1:0] smp,
                            input logic [COEF_ADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] coef,
                            input logic typed, input logic [SAMPLE_W-1:0] typed_val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.sample_in  <= smp;
        in_ch.coef_addr  <= addr;
        in_ch.coef_value <= coef;
        row_typed        <= typed;
        row_typed_val    <= typed_val;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait out every due output and let a trailing write or push finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly modest coefficients so that sums do not always saturate
    function automatic logic [SAMPLE_W-1:0] rand_coef();
        int c;
        if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom);
        c = int'($urandom_range(0, 8191)) - 4096;
        return c[SAMPLE_W-1:0];
    endfunction

    initial begin : stimulus
        idle_mode_e          mode;
        logic [SAMPLE_W-1:0] smp;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_PUSH;
        in_ch.sample_in  = '0;
        in_ch.coef_addr  = '0;
        in_ch.coef_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_PHASE_COUNT;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;
        row_typed        = 1'b0;
        row_typed_val    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every tap of the phases the ratios reach, so no read hits an unwritten entry
        for (int a = 0; a < FILL_PHASES * TAPS; a++)
            send_txn(FUNC_COEF, SAMPLE_W'($urandom), COEF_ADDR_W'(a), rand_coef(), 1'b0, '0);
        settle();

        // Directed table at the reset ratio
        write_reg(CFG_TAP_COUNT, 9'd4);
        foreach (dir_rows[r]) begin
            if (dir_rows[r].func == FUNC_PUSH)
                send_txn(FUNC_PUSH, dir_rows[r].data, COEF_ADDR_W'($urandom), rand_coef(),
                         dir_rows[r].typed, dir_rows[r].typed_val);
            else
                send_txn(FUNC_COEF, SAMPLE_W'($urandom), dir_rows[r].addr, dir_rows[r].data,
                         1'b0, '0);
        end
        settle();

        // Random phases, one ratio each, rotating through the idle modes
        foreach (ratios[ph]) begin
            mode = idle_mode_e'(ph % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 67; stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 67; end
                default:       begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            write_reg(CFG_PHASE_COUNT, ratios[ph].pc);
            write_reg(CFG_INT_STEP, ratios[ph].istep);
            write_reg(CFG_FRAC_STEP, ratios[ph].fstep);
            write_reg(CFG_TAP_COUNT, ratios[ph].taps);
            for (int k = 0; k < int'(ratios[ph].items); k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_txn(FUNC_COEF, SAMPLE_W'($urandom),
                             COEF_ADDR_W'($urandom_range(0, COEF_DEPTH - 1)), rand_coef(),
                             1'b0, '0);
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        smp = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
                    else
                        smp = SAMPLE_W'($urandom);
                    send_txn(FUNC_PUSH, smp, COEF_ADDR_W'($urandom), rand_coef(), 1'b0, '0);
                end
            end
            settle();
        end

        // Catch any stray output after the last expected one
        repeat (TAPS + 8) @(posedge i_clk);
        if (!mismatch_seen && due_outputs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
